### hw/rtl/hwf_pkg.sv
// shared constants, types and seed table for the holt-winters forecaster
package hwf_pkg;

    localparam int SEASON_LEN = 56;
    localparam int FRAC_BITS  = 16;
    localparam int SEED_COUNT = 56;

    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 17;
    localparam int HORIZON_W  = 6;
    localparam int PHASE_W    = (SEASON_LEN > 1) ? $clog2(SEASON_LEN) : 1;
    localparam int CFG_IDX_W  = 3;

    // multiplier operand is a difference of up to three 32-bit terms
    localparam int OPND_W     = DATA_W + 2;
    localparam int PROD_W     = GAIN_W + OPND_W + 1;
    localparam int ACC_W      = PROD_W;

    localparam int HORIZON_MAX = (1 << HORIZON_W) - 1;
    localparam int SUM_W       = ((PHASE_W > HORIZON_W) ? PHASE_W : HORIZON_W) + 1;
    localparam int WRAP_STEPS  = (SEASON_LEN + HORIZON_MAX - 1) / SEASON_LEN;

    localparam logic [GAIN_W-1:0]         GAIN_RESET    = GAIN_W'(32768);
    localparam logic [HORIZON_W-1:0]      HORIZON_RESET = HORIZON_W'(1);
    localparam logic signed [DATA_W-1:0]  LEVEL_SEED    = DATA_W'(72052);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sh0000_0000_8000_0000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_KEEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TREND_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TREND_KEEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEASON_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEASON_KEEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZON     = 3'd6;

    // accumulator operations of the shared multiply unit
    localparam logic [1:0] ACC_HOLD  = 2'd0;
    localparam logic [1:0] ACC_FIRST = 2'd1;
    localparam logic [1:0] ACC_LOAD  = 2'd2;

    typedef struct packed {
        logic                       mul_go;
        logic                       shift;
        logic [GAIN_W-1:0]          gain;
        logic signed [OPND_W-1:0]   opnd;
        logic [1:0]                 acc_op;
        logic signed [ACC_W-1:0]    load_val;
    } mac_ctrl_t;

    typedef logic signed [DATA_W-1:0] seed_list_t [SEED_COUNT];
    typedef logic signed [DATA_W-1:0] season_init_t [SEASON_LEN];

    localparam seed_list_t SEASON_SEED = '{
        -61181, -61787,  49524, -53506, -53768,  -5810, 115061,    350,
        -60959, -61911,  37969, -49575, -47369,   3780, 125861,  -7059,
        -60392, -61727,  34235, -43359, -43702,   4286, 101323,   5985,
        -61806, -61211,  33264, 162356,  77104,  54080,  55736, -13473,
        -61973, -61360,  22654,  81055,  67155,  36292,  66260, -16126,
        -60736, -61719,  40689, -45926, -50220, -12309, 107677, -11045,
        -61666, -61797,  30350, -50578, -53010,   1749, 106902,  -4195
    };

    function automatic season_init_t build_season_init();
        season_init_t r;
        for (int i = 0; i < SEASON_LEN; i++)
        begin
            r[i] = SEASON_SEED[i % SEED_COUNT];
        end
        return r;
    endfunction

    localparam season_init_t SEASON_INIT = build_season_init();

endpackage

### hw/rtl/hwf_ram.sv
// generic single write, single read ram with registered read data
module hwf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

### hw/rtl/hwf_mac.sv
// shared multiply unit with scaling, accumulator and saturation
module hwf_mac import hwf_pkg::*; (
    input  logic                        clk,
    input  mac_ctrl_t                   ctrl,
    output logic signed [DATA_W-1:0]    sat_sum
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     shift_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  scaled;
    logic signed [ACC_W-1:0]  sum;
    logic signed [GAIN_W:0]   gain_s;

    assign gain_s    = $signed({1'b0, ctrl.gain});
    assign prod_next = gain_s * ctrl.opnd;

    // arithmetic shift gives floor division by the unity gain
    assign scaled = shift_reg ? (prod_reg >>> FRAC_BITS) : prod_reg;
    assign sum    = acc_reg + scaled;

    always_comb
    begin
        if (sum > SAT_MAX)
        begin
            sat_sum = SAT_MAX[DATA_W-1:0];
        end
        else if (sum < SAT_MIN)
        begin
            sat_sum = SAT_MIN[DATA_W-1:0];
        end
        else
        begin
            sat_sum = sum[DATA_W-1:0];
        end
    end

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_HOLD:  acc_next = acc_reg;
            ACC_FIRST: acc_next = scaled;
            ACC_LOAD:  acc_next = ctrl.load_val;
            default:   acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_go)
        begin
            prod_reg  <= prod_next;
            shift_reg <= ctrl.shift;
        end
        acc_reg <= acc_next;
    end

endmodule

### hw/rtl/holt_winters_forecaster_unit.sv
// additive holt-winters forecaster: sequencer, state and configuration
//
//  channel  direction  handshake           payload
//  input    in         in_valid/in_stall   sample    [31:0] signed
//  output   out        out_valid/out_stall forecast  [31:0] signed
//  config   in         cfg_valid/cfg_ready cfg_index [2:0], cfg_data [16:0]
//
// an item runs through two season table reads and seven products through the
// one shared multiplier plus a final sum before the next can be accepted. the
// final step waits while the output register still holds an untaken result.
// reset loads register defaults, the level seed and zero trend; season entries
// read as their seeds until written, tracked by one valid flop per entry, so no
// clearing pass is needed.
module holt_winters_forecaster_unit import hwf_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [DATA_W-1:0]    sample,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [DATA_W-1:0]    forecast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [GAIN_W-1:0]           cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD_P = 4'd1;
    localparam logic [3:0] ST_RD_Q = 4'd2;
    localparam logic [3:0] ST_L1   = 4'd3;
    localparam logic [3:0] ST_L2   = 4'd4;
    localparam logic [3:0] ST_S1   = 4'd5;
    localparam logic [3:0] ST_S2   = 4'd6;
    localparam logic [3:0] ST_T1   = 4'd7;
    localparam logic [3:0] ST_T2   = 4'd8;
    localparam logic [3:0] ST_F1   = 4'd9;
    localparam logic [3:0] ST_F2   = 4'd10;

    logic [3:0] state_reg, state_next;

    logic [GAIN_W-1:0]    level_gain_reg, level_keep_reg;
    logic [GAIN_W-1:0]    trend_gain_reg, trend_keep_reg;
    logic [GAIN_W-1:0]    season_gain_reg, season_keep_reg;
    logic [HORIZON_W-1:0] horizon_reg;

    logic signed [DATA_W-1:0] level_reg, trend_reg;
    logic [PHASE_W-1:0]       phase_reg;
    logic [SEASON_LEN-1:0]    seeded_reg;

    logic signed [DATA_W-1:0] x_reg, cs_reg, sq_reg, nl_reg, nt_reg;
    logic signed [DATA_W-1:0] forecast_reg;
    logic                     out_valid_reg;
    logic [PHASE_W-1:0]       rd_addr_reg;

    logic                     in_accept;
    logic                     out_free;
    logic                     finish;
    logic [PHASE_W-1:0]       q_idx;
    logic [SUM_W-1:0]         q_sum;
    logic                     ram_we, ram_re;
    logic [PHASE_W-1:0]       ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    logic signed [DATA_W-1:0] entry_val;
    logic signed [DATA_W-1:0] sat_sum;
    mac_ctrl_t                mac_ctrl;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign finish    = (state_reg == ST_F2) && out_free;
    assign out_valid = out_valid_reg;
    assign forecast  = forecast_reg;
    assign cfg_ready = 1'b1;

    // season index of the forecast, wrapped by repeated compare and subtract
    always_comb
    begin
        q_sum = SUM_W'(phase_reg) + SUM_W'(horizon_reg);
        for (int k = 0; k < WRAP_STEPS; k++)
        begin
            if (q_sum >= SUM_W'(SEASON_LEN))
            begin
                q_sum = q_sum - SUM_W'(SEASON_LEN);
            end
        end
        q_idx = q_sum[PHASE_W-1:0];
    end

    // never-written entries read as their trained seed
    assign entry_val = seeded_reg[rd_addr_reg] ? $signed(ram_rdata)
                                               : SEASON_INIT[rd_addr_reg];

    assign ram_re    = in_accept || (state_reg == ST_RD_P);
    assign ram_raddr = (state_reg == ST_RD_P) ? q_idx : phase_reg;
    assign ram_we    = (state_reg == ST_S2);

    hwf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SEASON_LEN)
    ) u_season_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (phase_reg),
        .wr_data (sat_sum),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        mac_ctrl          = '0;
        mac_ctrl.shift    = 1'b1;
        mac_ctrl.acc_op   = ACC_HOLD;
        mac_ctrl.load_val = ACC_W'(nl_reg) + ACC_W'(sq_reg);
        case (state_reg)
            ST_RD_Q:
            begin
                mac_ctrl.mul_go = 1'b1;
                mac_ctrl.gain   = level_gain_reg;
                mac_ctrl.opnd   = OPND_W'(x_reg) - OPND_W'(cs_reg);
            end
            ST_L1:
            begin
                mac_ctrl.mul_go = 1'b1;
                mac_ctrl.gain   = level_keep_reg;
                mac_ctrl.opnd   = OPND_W'(level_reg) + OPND_W'(trend_reg);
                mac_ctrl.acc_op = ACC_FIRST;
            end
            ST_L2:
            begin
                mac_ctrl.mul_go = 1'b1;
                mac_ctrl.gain   = season_gain_reg;
                mac_ctrl.opnd   = OPND_W'(x_reg) - OPND_W'(level_reg)
                                  - OPND_W'(trend_reg);
            end
            ST_S1:
            begin
                mac_ctrl.mul_go = 1'b1;
                mac_ctrl.gain   = season_keep_reg;
                mac_ctrl.opnd   = OPND_W'(cs_reg);
                mac_ctrl.acc_op = ACC_FIRST;
            end
            ST_S2:
            begin
                mac_ctrl.mul_go = 1'b1;
                mac_ctrl.gain   = trend_gain_reg;
                mac_ctrl.opnd   = OPND_W'(nl_reg) - OPND_W'(level_reg);
            end
            ST_T1:
            begin
                mac_ctrl.mul_go = 1'b1;
                mac_ctrl.gain   = trend_keep_reg;
                mac_ctrl.opnd   = OPND_W'(trend_reg);
                mac_ctrl.acc_op = ACC_FIRST;
            end
            ST_T2:
            begin
                mac_ctrl.acc_op = ACC_LOAD;
            end
            ST_F1:
            begin
                // horizon times trend is an integer product, no scaling
                mac_ctrl.mul_go = 1'b1;
                mac_ctrl.shift  = 1'b0;
                mac_ctrl.gain   = GAIN_W'(horizon_reg);
                mac_ctrl.opnd   = OPND_W'(nt_reg);
            end
            default:
            begin
                mac_ctrl.mul_go = 1'b0;
            end
        endcase
    end

    hwf_mac u_mac (
        .clk     (clk),
        .ctrl    (mac_ctrl),
        .sat_sum (sat_sum)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: state_next = in_accept ? ST_RD_P : ST_IDLE;
            ST_RD_P: state_next = ST_RD_Q;
            ST_RD_Q: state_next = ST_L1;
            ST_L1:   state_next = ST_L2;
            ST_L2:   state_next = ST_S1;
            ST_S1:   state_next = ST_S2;
            ST_S2:   state_next = ST_T1;
            ST_T1:   state_next = ST_T2;
            ST_T2:   state_next = ST_F1;
            ST_F1:   state_next = ST_F2;
            ST_F2:   state_next = out_free ? ST_IDLE : ST_F2;
            default: state_next = ST_IDLE;
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg <= sample;
        end
        if (ram_re)
        begin
            rd_addr_reg <= ram_raddr;
        end
        if (state_reg == ST_RD_P)
        begin
            cs_reg <= entry_val;
        end
        if (state_reg == ST_RD_Q)
        begin
            sq_reg <= entry_val;
        end
        if (state_reg == ST_L2)
        begin
            nl_reg <= sat_sum;
        end
        if (state_reg == ST_T2)
        begin
            nt_reg <= sat_sum;
        end
        if (finish)
        begin
            forecast_reg <= sat_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            level_gain_reg  <= GAIN_RESET;
            level_keep_reg  <= GAIN_RESET;
            trend_gain_reg  <= GAIN_RESET;
            trend_keep_reg  <= GAIN_RESET;
            season_gain_reg <= GAIN_RESET;
            season_keep_reg <= GAIN_RESET;
            horizon_reg     <= HORIZON_RESET;
            level_reg       <= LEVEL_SEED;
            trend_reg       <= '0;
            phase_reg       <= '0;
            seeded_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LEVEL_GAIN:  level_gain_reg  <= cfg_data;
                    REG_LEVEL_KEEP:  level_keep_reg  <= cfg_data;
                    REG_TREND_GAIN:  trend_gain_reg  <= cfg_data;
                    REG_TREND_KEEP:  trend_keep_reg  <= cfg_data;
                    REG_SEASON_GAIN: season_gain_reg <= cfg_data;
                    REG_SEASON_KEEP: season_keep_reg <= cfg_data;
                    REG_HORIZON:     horizon_reg     <= cfg_data[HORIZON_W-1:0];
                    default:         ;
                endcase
            end
            if (ram_we)
            begin
                seeded_reg[phase_reg] <= 1'b1;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                level_reg     <= nl_reg;
                trend_reg     <= nt_reg;
                phase_reg     <= (phase_reg == PHASE_W'(SEASON_LEN - 1))
                                 ? '0 : phase_reg + 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_RD_P))
        else $error("accepted sample did not start the season read");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_F2))
        else $error("result appeared outside the final step");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(level_reg) |-> $past(finish))
        else $error("level changed without a finished item");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_W'(SEASON_LEN - 1))
        else $error("season phase out of range");

endmodule

### sim/testbench.sv
// self-checking testbench for the holt-winters forecaster unit
`timescale 1ns / 1ps

module testbench;
    import hwf_pkg::*;

    localparam int     HALF_PERIOD = 10;
    localparam int     RESET_CYCLES = 8;
    localparam int     DRAIN_CYCLES = 24;
    localparam int     MAX_GAP = 24;
    localparam int     MAX_PRINTED = 40;
    localparam longint TIMEOUT_NS = 8_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;
    localparam logic [GAIN_W-1:0] TOP_GAIN   = 17'd131071;
    localparam logic [GAIN_W-1:0] HALF_GAIN  = 17'd32768;

    localparam logic signed [DATA_W-1:0] START_LEVEL = 32'sd72052;
    localparam logic signed [DATA_W-1:0] POS_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] NEG_MAX = 32'sh80000000;

    localparam logic [GAIN_W-1:0] GAIN_EXTREMES [3] = '{17'd0, 17'd65536, 17'd131071};
    localparam logic signed [DATA_W-1:0] SAMPLE_EXTREMES [4] =
        '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1};

    // trained season shape loaded at reset
    localparam int SEED_TABLE [56] = '{
        -61181, -61787,  49524, -53506, -53768,  -5810, 115061,    350,
        -60959, -61911,  37969, -49575, -47369,   3780, 125861,  -7059,
        -60392, -61727,  34235, -43359, -43702,   4286, 101323,   5985,
        -61806, -61211,  33264, 162356,  77104,  54080,  55736, -13473,
        -61973, -61360,  22654,  81055,  67155,  36292,  66260, -16126,
        -60736, -61719,  40689, -45926, -50220, -12309, 107677, -11045,
        -61666, -61797,  30350, -50578, -53010,   1749, 106902,  -4195
    };

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [DATA_W-1:0]    sample;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [DATA_W-1:0]    forecast;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [GAIN_W-1:0]           cfg_data;

    // forecaster state as predicted
    logic signed [DATA_W-1:0]    pred_level;
    logic signed [DATA_W-1:0]    pred_trend;
    logic signed [DATA_W-1:0]    pred_season [SEASON_LEN];
    int                          pred_phase;
    logic [GAIN_W-1:0]           gain_level, keep_level, gain_trend, keep_trend;
    logic [GAIN_W-1:0]           gain_season, keep_season;
    logic [HORIZON_W-1:0]        pred_horizon;

    logic signed [DATA_W-1:0]    pending_forecasts [$];

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_request;
    int samples_sent;
    int forecasts_checked;
    int reg_writes;
    int mismatches;
    int signal_step;

    holt_winters_forecaster_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .forecast  (forecast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    function automatic longint weigh(input logic [GAIN_W-1:0] g, input longint v);
        // exact product then floor shift
        return (longint'(g) * v) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [DATA_W-1:0] saturate(input longint v);
        if (v > 64'sd2147483647)
            return POS_MAX;
        if (v < -64'sd2147483648)
            return NEG_MAX;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] predict_forecast(
        input logic signed [DATA_W-1:0] x);
        int p, q;
        longint xl, old_l, old_t, cur_s, fc;
        logic signed [DATA_W-1:0] new_l, new_t;
        p = pred_phase;
        q = (p + int'(pred_horizon)) % SEASON_LEN;
        xl = x;
        old_l = pred_level;
        old_t = pred_trend;
        cur_s = pred_season[p];
        new_l = saturate(weigh(gain_level, xl - cur_s) + weigh(keep_level, old_l + old_t));
        new_t = saturate(weigh(gain_trend, longint'(new_l) - old_l) +
                         weigh(keep_trend, old_t));
        // forecast reads the season entry before this step's update
        fc = longint'(new_l) + longint'(pred_horizon) * longint'(new_t) +
             longint'(pred_season[q]);
        pred_season[p] = saturate(weigh(gain_season, xl - old_l - old_t) +
                                  weigh(keep_season, cur_s));
        pred_level = new_l;
        pred_trend = new_t;
        pred_phase = (p + 1 >= SEASON_LEN) ? 0 : p + 1;
        return saturate(fc);
    endfunction

    function automatic int pick_gap(input int pct);
        int g;
        g = 0;
        while (g < MAX_GAP && $urandom_range(99) < pct)
            g++;
        return g;
    endfunction

    function automatic logic signed [DATA_W-1:0] next_sample();
        int sel;
        int jitter;
        sel = $urandom_range(99);
        signal_step++;
        jitter = int'($urandom_range(16383)) - 8192;
        if (sel < 70)
            return DATA_W'(SEED_TABLE[signal_step % SEASON_LEN] + int'(START_LEVEL) + jitter);
        if (sel < 90)
            return DATA_W'($urandom);
        return SAMPLE_EXTREMES[$urandom_range(3)];
    endfunction

    task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] got,
                                   input logic signed [DATA_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch on %s: got %0d expected %0d at %0t ns", what, got, want, $time);
    endtask

    // one input transaction, entered and left on a rising edge
    task automatic send_sample(input logic signed [DATA_W-1:0] x);
        int gap;
        in_valid <= 1'b1;
        sample   <= x;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        pending_forecasts.push_back(predict_forecast(x));
        samples_sent++;
        gap = pick_gap(tx_idle_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        case (idx)
            REG_LEVEL_GAIN:  gain_level   = val;
            REG_LEVEL_KEEP:  keep_level   = val;
            REG_TREND_GAIN:  gain_trend   = val;
            REG_TREND_KEEP:  keep_trend   = val;
            REG_SEASON_GAIN: gain_season  = val;
            REG_SEASON_KEEP: keep_season  = val;
            REG_HORIZON:     pred_horizon = val[HORIZON_W-1:0];
            default:         ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_gains(input logic [GAIN_W-1:0] lg, input logic [GAIN_W-1:0] lk,
                                 input logic [GAIN_W-1:0] tg, input logic [GAIN_W-1:0] tk,
                                 input logic [GAIN_W-1:0] sg, input logic [GAIN_W-1:0] sk,
                                 input logic [GAIN_W-1:0] h);
        write_reg(REG_LEVEL_GAIN, lg);
        write_reg(REG_LEVEL_KEEP, lk);
        write_reg(REG_TREND_GAIN, tg);
        write_reg(REG_TREND_KEEP, tk);
        write_reg(REG_SEASON_GAIN, sg);
        write_reg(REG_SEASON_KEEP, sk);
        write_reg(REG_HORIZON, h);
    endtask

    // wait until every forecast is back, then let the pipeline go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_forecasts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic pick_gains();
        logic [GAIN_W-1:0] g [6];
        logic [GAIN_W-1:0] w;
        int mode;
        mode = $urandom_range(3);
        for (int i = 0; i < 6; i += 2)
        begin
            case (mode)
                0:
                begin
                    w = GAIN_W'($urandom_range(65536));
                    g[i] = w;
                    g[i+1] = UNITY_GAIN - w;
                end
                1:
                begin
                    g[i] = GAIN_W'($urandom_range(131071));
                    g[i+1] = GAIN_W'($urandom_range(131071));
                end
                2:
                begin
                    g[i] = GAIN_EXTREMES[$urandom_range(2)];
                    g[i+1] = GAIN_EXTREMES[$urandom_range(2)];
                end
                default:
                begin
                    // slow smoothing
                    w = GAIN_W'($urandom_range(8192));
                    g[i] = w;
                    g[i+1] = UNITY_GAIN - w;
                end
            endcase
        end
        program_gains(g[0], g[1], g[2], g[3], g[4], g[5], GAIN_W'($urandom_range(63)));
    endtask

    task automatic test_reset_defaults();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        send_sample(32'sd0);
        send_sample(POS_MAX);
        send_sample(NEG_MAX);
        send_sample(-32'sd1);
        send_sample(32'sd1);
        send_sample(START_LEVEL);
        settle();
    endtask

    task automatic test_gain_extremes();
        // gains above unity and the largest horizon drive everything into saturation
        program_gains(TOP_GAIN, TOP_GAIN, TOP_GAIN, TOP_GAIN, TOP_GAIN, TOP_GAIN, 17'd63);
        write_reg(REG_SPARE, 17'h1ffff);
        send_sample(POS_MAX);
        send_sample(NEG_MAX);
        send_sample(POS_MAX);
        send_sample(NEG_MAX);
        settle();
        program_gains(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
        send_sample(32'sd123456);
        send_sample(-32'sd654321);
        settle();
        // horizon equal to the season length wraps the season index only
        program_gains(UNITY_GAIN, UNITY_GAIN, UNITY_GAIN, UNITY_GAIN, UNITY_GAIN, UNITY_GAIN,
                      17'd56);
        send_sample(32'sd65536);
        send_sample(-32'sd131072);
        send_sample(32'sd200000);
        settle();
        program_gains(UNITY_GAIN, 17'd0, UNITY_GAIN, 17'd0, UNITY_GAIN, 17'd0, 17'd55);
        send_sample(32'sd1000000);
        send_sample(-32'sd1000000);
        settle();
        // upper data bits on a horizon write are dropped
        program_gains(HALF_GAIN, HALF_GAIN, HALF_GAIN, HALF_GAIN, HALF_GAIN, HALF_GAIN,
                      17'h1ffc5);
        send_sample(32'sd70000);
        send_sample(32'sd10000);
        settle();
    endtask

    task automatic test_random_phase(input int items, input int tx_pct, input int rx_pct);
        pick_gains();
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (items) send_sample(next_sample());
        settle();
    endtask

    task automatic test_output_holdoff();
        pick_gains();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_request = 300;
        repeat (40) send_sample(next_sample());
        settle();
    endtask

    task automatic test_pause_and_resume();
        pick_gains();
        tx_idle_pct = 28;
        rx_stall_pct = 55;
        repeat (15) send_sample(next_sample());
        settle();
        repeat (15) send_sample(next_sample());
        settle();
    endtask

    // receiver: random stall plus long hold-offs on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // outputs are stable at the falling edge ahead of the accepting edge
    initial
    begin
        logic signed [DATA_W-1:0] want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_forecasts.size() == 0)
                    report_mismatch("forecast with none pending", forecast, '0);
                else
                begin
                    want = pending_forecasts.pop_front();
                    forecasts_checked++;
                    if (forecast !== want)
                        report_mismatch("forecast", forecast, want);
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d forecasts outstanding", pending_forecasts.size());
        $display("holt_winters_forecaster_unit regression: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_request = 0;
        samples_sent = 0;
        forecasts_checked = 0;
        reg_writes = 0;
        mismatches = 0;
        signal_step = 0;
        gain_level = HALF_GAIN;
        keep_level = HALF_GAIN;
        gain_trend = HALF_GAIN;
        keep_trend = HALF_GAIN;
        gain_season = HALF_GAIN;
        keep_season = HALF_GAIN;
        pred_horizon = 6'd1;
        pred_level = START_LEVEL;
        pred_trend = '0;
        pred_phase = 0;
        for (int i = 0; i < SEASON_LEN; i++)
            pred_season[i] = DATA_W'(SEED_TABLE[i % 56]);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_gain_extremes();
        for (int round = 0; round < 2; round++)
        begin
            test_random_phase(110, 0, 0);
            test_random_phase(110, 55, 0);
            test_random_phase(110, 0, 55);
            test_random_phase(110, 28, 28);
        end
        test_output_holdoff();
        test_pause_and_resume();
        settle();

        $display("run covered %0d samples, %0d forecasts compared, %0d register writes",
                 samples_sent, forecasts_checked, reg_writes);
        $display("gain extremes, horizon wrap, saturation, idle and stall mixes, long hold-off");
        if (mismatches == 0)
            $display("holt_winters_forecaster_unit regression: pass");
        else
            $display("holt_winters_forecaster_unit regression: fail");
        $finish;
    end

endmodule

### sim.f
hw/rtl/hwf_pkg.sv
hw/rtl/hwf_ram.sv
hw/rtl/hwf_mac.sv
hw/rtl/holt_winters_forecaster_unit.sv
sim/testbench.sv
